// ===== sv/pqe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle quad expander package
// Shared beat types, corner codes, saturation and the fixed sine table.
// ----------------------------------------------------------------------------
package pqe_pkg;

  localparam int TrigTableBits = 10;
  localparam int TrigN         = 1 << TrigTableBits;
  localparam int TrigQ         = TrigN >> 2;
  localparam int QuarterBits   = TrigTableBits - 2;

  localparam int TickW = 12;
  localparam logic [TickW-1:0] TickReset = TickW'(16);

  localparam int AddrW = 3;
  localparam logic RegTickStep = 1'b0;

  localparam int VertsPerQuad = 6;
  localparam logic [2:0] LastVert = 3'(VertsPerQuad - 1);

  localparam logic [1:0] CornerTl = 2'd0;
  localparam logic [1:0] CornerTr = 2'd1;
  localparam logic [1:0] CornerBr = 2'd2;
  localparam logic [1:0] CornerBl = 2'd3;

  localparam logic [63:0] PiHalfQ30 = 64'd1686629713;
  localparam logic [63:0] OneQ30    = 64'd1 << 30;
  localparam logic [63:0] TrigQ64   = 64'(TrigQ);
  localparam logic [QuarterBits:0] QuarterFull = (QuarterBits + 1)'(TrigQ);

  typedef struct packed {
    logic signed [15:0] life_in;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] size_x;
    logic signed [15:0] size_y;
    logic        [15:0] angle;
    logic signed [15:0] opacity;
  } item_t;

  typedef struct packed {
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic        [1:0]  corner_id;
    logic signed [15:0] vert_alpha;
    logic signed [15:0] life_out;
    logic signed [15:0] pos_x_out;
    logic signed [15:0] pos_y_out;
    logic               alive;
    logic               last;
  } res_t;

  // Everything the expansion stage needs to produce the beats of one particle.
  typedef struct packed {
    logic               live;
    logic signed [17:0] a00;
    logic signed [17:0] a01;
    logic signed [17:0] a10;
    logic signed [17:0] a11;
    logic signed [17:0] cx;
    logic signed [17:0] cy;
    logic signed [15:0] opacity;
    logic signed [15:0] life;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } quad_t;

  typedef logic [TrigQ-1:0][15:0] qtab_t;

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    if (v > 24'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -24'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Q30 quarter-wave series, evaluated only while the table is elaborated.
  function automatic logic [15:0] quarter_sine(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = (r * PiHalfQ30) / TrigQ64;
    x2 = (x * x) >> 30;
    t  = OneQ30;
    t  = OneQ30 - ((x2 * t) >> 30) / 64'd156;
    t  = OneQ30 - ((x2 * t) >> 30) / 64'd110;
    t  = OneQ30 - ((x2 * t) >> 30) / 64'd72;
    t  = OneQ30 - ((x2 * t) >> 30) / 64'd42;
    t  = OneQ30 - ((x2 * t) >> 30) / 64'd20;
    t  = OneQ30 - ((x2 * t) >> 30) / 64'd6;
    return 16'((((x * t) >> 30) + 64'd131072) >> 18);
  endfunction

  function automatic qtab_t build_quarter();
    qtab_t tab;
    for (int r = 0; r < TrigQ; r++) begin
      tab[r] = quarter_sine(64'(r));
    end
    return tab;
  endfunction

  localparam qtab_t QuarterTab = build_quarter();
  localparam logic [15:0] QuarterTop = quarter_sine(TrigQ64);

  // Full-wave sine from the quarter table by folding the phase.
  function automatic logic signed [15:0] trig_lookup(input logic [TrigTableBits-1:0] idx);
    logic [1:0]             quad;
    logic [QuarterBits-1:0] r;
    logic [QuarterBits:0]   rr;
    logic [15:0]            mag;
    quad = idx[TrigTableBits-1 -: 2];
    r    = idx[QuarterBits-1:0];
    rr   = quad[0] ? (QuarterFull - {1'b0, r}) : {1'b0, r};
    mag  = rr[QuarterBits] ? QuarterTop : QuarterTab[rr[QuarterBits-1:0]];
    return quad[1] ? 16'(-$signed(mag)) : $signed(mag);
  endfunction

endpackage

// ===== sv/pqe_expand.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle quad expander, expansion stage
// Holds one particle and emits its six vertex beats, or one death beat.
// ----------------------------------------------------------------------------
module pqe_expand import pqe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  quad_valid_i,
  input  quad_t quad_i,
  output logic  quad_ready_o,
  output logic  res_valid_o,
  output res_t  res_o
);

  logic        seq_valid_q;
  quad_t       seq_q;
  logic [2:0]  cnt_q;
  logic        seq_done;
  logic        res_valid_q;
  res_t        res_q;
  res_t        res_d;
  logic [1:0]  corner;
  logic        neg_x;
  logic        neg_y;
  logic signed [19:0] sum_x;
  logic signed [19:0] sum_y;

  assign seq_done     = seq_valid_q && (!seq_q.live || cnt_q == LastVert);
  assign quad_ready_o = !seq_valid_q || seq_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_valid_q <= 1'b0;
      cnt_q       <= 3'd0;
    end else if (quad_ready_o) begin
      seq_valid_q <= quad_valid_i;
      cnt_q       <= 3'd0;
    end else begin
      cnt_q <= cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (quad_ready_o) begin
      seq_q <= quad_i;
    end
  end

  // Triangles tl,tr,br then tl,br,bl.
  always_comb begin
    case (cnt_q)
      3'd0:    corner = CornerTl;
      3'd1:    corner = CornerTr;
      3'd2:    corner = CornerBr;
      3'd3:    corner = CornerTl;
      3'd4:    corner = CornerBr;
      3'd5:    corner = CornerBl;
      default: corner = CornerTl;
    endcase
  end

  assign neg_x = (corner == CornerTl) || (corner == CornerBl);
  assign neg_y = (corner == CornerBr) || (corner == CornerBl);

  assign sum_x = (neg_x ? -20'(seq_q.a00) : 20'(seq_q.a00))
               + (neg_y ? -20'(seq_q.a10) : 20'(seq_q.a10)) + 20'(seq_q.cx);
  assign sum_y = (neg_x ? -20'(seq_q.a01) : 20'(seq_q.a01))
               + (neg_y ? -20'(seq_q.a11) : 20'(seq_q.a11)) + 20'(seq_q.cy);

  always_comb begin
    res_d.pos_x_out = seq_q.pos_x;
    res_d.pos_y_out = seq_q.pos_y;
    if (seq_q.live) begin
      res_d.vert_x     = sat16(24'(sum_x));
      res_d.vert_y     = sat16(24'(sum_y));
      res_d.corner_id  = corner;
      res_d.vert_alpha = seq_q.opacity;
      res_d.life_out   = seq_q.life;
      res_d.alive      = 1'b1;
      res_d.last       = (cnt_q == LastVert);
    end else begin
      res_d.vert_x     = '0;
      res_d.vert_y     = '0;
      res_d.corner_id  = CornerTl;
      res_d.vert_alpha = '0;
      res_d.life_out   = '0;
      res_d.alive      = 1'b0;
      res_d.last       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= seq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== sv/particle_quad_expander.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle quad expander
// Ages one particle, moves it and expands it into a rotated, scaled quad.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                          Payload
// item      in         start high and busy low            item_i (item_t)
// result    out        res_valid_o, one cycle, no stall   res_o (res_t)
// config    in/out     APB, write when psel/penable/pwrite tick_step at 0x0
//
// A live particle occupies the expansion stage for six vertex beats, one beat
// per cycle; a dead particle gives a single beat. The first beat is registered
// through stages one to three, then the expansion stage's particle and result.
// Three compute stages feed the expansion stage; busy rises only when all of
// them hold a particle and the expansion stage is not on its final beat.
// Reset clears all valid bits and sets tick_step to 16; no clearing pass.
// ----------------------------------------------------------------------------
module particle_quad_expander import pqe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  item_t            item_i,
  output logic             res_valid_o,
  output res_t             res_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef struct packed {
    logic               live;
    logic signed [15:0] life;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [28:0] step_x;
    logic signed [28:0] step_y;
    logic signed [15:0] size_x;
    logic signed [15:0] size_y;
    logic signed [15:0] opacity;
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
  } st2_t;

  typedef struct packed {
    logic               live;
    logic signed [15:0] life;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] opacity;
    logic signed [31:0] m_xc;
    logic signed [31:0] m_xs;
    logic signed [31:0] m_ys;
    logic signed [31:0] m_yc;
  } st3_t;

  logic [TickW-1:0] tick_step_q;
  logic             cfg_write;

  logic  s1_valid_q, s2_valid_q, s3_valid_q;
  logic  s1_ready, s2_ready, s3_ready, quad_ready;
  logic  accept;
  item_t s1_q;
  st2_t  s2_q, s2_d;
  st3_t  s3_q, s3_d;
  quad_t quad_d;

  logic signed [17:0]              life_wide;
  logic [TrigTableBits-1:0]        sin_idx;
  logic [TrigTableBits-1:0]        cos_idx;
  logic signed [29:0]              rnd_x, rnd_y;
  logic signed [15:0]              new_x, new_y;
  logic signed [32:0]              rnd_xc, rnd_xs, rnd_ys, rnd_yc;

  // Configuration port.
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == RegTickStep) ? {20'd0, tick_step_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_step_q <= TickReset;
    end else if (cfg_write && paddr[2] == RegTickStep) begin
      tick_step_q <= pwdata[TickW-1:0];
    end
  end

  // Stall chain.
  assign s3_ready = !s3_valid_q || quad_ready;
  assign s2_ready = !s2_valid_q || s3_ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign busy     = !s1_ready;
  assign accept   = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= accept;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_q <= item_i;
    end
    if (s2_ready) begin
      s2_q <= s2_d;
    end
    if (s3_ready) begin
      s3_q <= s3_d;
    end
  end

  // Stage one: age, liveness, position step products and table reads.
  assign life_wide = 18'(s1_q.life_in) - $signed({6'd0, tick_step_q});
  assign sin_idx   = s1_q.angle[15 -: TrigTableBits];
  assign cos_idx   = sin_idx + TrigTableBits'(TrigQ);

  always_comb begin
    s2_d.life    = sat16(24'(life_wide));
    s2_d.live    = (s2_d.life > 16'sd0) && (s1_q.opacity > 16'sd0)
                && (s1_q.size_x > 16'sd0) && (s1_q.size_y > 16'sd0);
    s2_d.pos_x   = s1_q.pos_x;
    s2_d.pos_y   = s1_q.pos_y;
    s2_d.step_x  = $signed({1'b0, tick_step_q}) * s1_q.dir_x;
    s2_d.step_y  = $signed({1'b0, tick_step_q}) * s1_q.dir_y;
    s2_d.size_x  = s1_q.size_x;
    s2_d.size_y  = s1_q.size_y;
    s2_d.opacity = s1_q.opacity;
    s2_d.sin_v   = trig_lookup(sin_idx);
    s2_d.cos_v   = trig_lookup(cos_idx);
  end

  // Stage two: new position and scale-by-rotation products.
  assign rnd_x = 30'(s2_q.step_x) + 30'sd128;
  assign rnd_y = 30'(s2_q.step_y) + 30'sd128;
  assign new_x = sat16(24'(s2_q.pos_x) + 24'(rnd_x >>> 8));
  assign new_y = sat16(24'(s2_q.pos_y) + 24'(rnd_y >>> 8));

  always_comb begin
    s3_d.live    = s2_q.live;
    s3_d.life    = s2_q.life;
    s3_d.pos_x   = s2_q.live ? new_x : s2_q.pos_x;
    s3_d.pos_y   = s2_q.live ? new_y : s2_q.pos_y;
    s3_d.opacity = s2_q.opacity;
    s3_d.m_xc    = s2_q.size_x * s2_q.cos_v;
    s3_d.m_xs    = s2_q.size_x * s2_q.sin_v;
    s3_d.m_ys    = s2_q.size_y * s2_q.sin_v;
    s3_d.m_yc    = s2_q.size_y * s2_q.cos_v;
  end

  // Stage three: round the matrix terms and place the quad center.
  assign rnd_xc = 33'(s3_q.m_xc) + 33'sd2048;
  assign rnd_xs = 33'(s3_q.m_xs) + 33'sd2048;
  assign rnd_ys = 33'(s3_q.m_ys) + 33'sd2048;
  assign rnd_yc = 33'(s3_q.m_yc) + 33'sd2048;

  always_comb begin
    quad_d.live    = s3_q.live;
    quad_d.a00     = 18'(rnd_xc >>> 12);
    quad_d.a01     = -18'(rnd_xs >>> 12);
    quad_d.a10     = 18'(rnd_ys >>> 12);
    quad_d.a11     = 18'(rnd_yc >>> 12);
    quad_d.cx      = $signed({s3_q.pos_x[15], s3_q.pos_x, 1'b0}) - 18'sd4096;
    quad_d.cy      = 18'sd4096 - $signed({s3_q.pos_y[15], s3_q.pos_y, 1'b0});
    quad_d.opacity = s3_q.opacity;
    quad_d.life    = s3_q.life;
    quad_d.pos_x   = s3_q.pos_x;
    quad_d.pos_y   = s3_q.pos_y;
  end

  pqe_expand u_expand (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .quad_valid_i (s3_valid_q),
    .quad_i       (quad_d),
    .quad_ready_o (quad_ready),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

endmodule

// ===== sv/pqe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle quad expander checker
// Port-level checks on the result beats, bound to the top level.
// ----------------------------------------------------------------------------
module pqe_checker import pqe_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  res_valid_o,
  input res_t  res_o
);

  a_dead_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.alive |-> res_o.last && res_o.life_out == 16'sd0)
    else $error("death beat is not a single beat with zero life");

  a_live_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.alive && !res_o.last |=> res_valid_o && res_o.alive)
    else $error("vertex beats of a live particle are not back to back");

  a_bl_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.alive |-> (res_o.corner_id == CornerBl) == res_o.last)
    else $error("bottom left corner and final beat disagree");

  a_live_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.alive |-> res_o.life_out > 16'sd0 && res_o.vert_alpha > 16'sd0)
    else $error("vertex beat of a particle that should have died");

endmodule

bind particle_quad_expander pqe_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
